// ----- sv/cvfm_pkg.sv -----
`default_nettype none

package cvfm_pkg;

   localparam int unsigned CHUNK_WIDTH_DEF  = 16;
   localparam int unsigned CHUNK_HEIGHT_DEF = 256;
   localparam int unsigned CHUNK_DEPTH_DEF  = 16;

   localparam int unsigned NUM_FACES     = 6;
   localparam int unsigned TILES_PER_ROW = 16;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned Y_CMP_WIDTH   = 13;

   localparam logic [2:0] FACE_POS_Y = 3'd0;
   localparam logic [2:0] FACE_NEG_Y = 3'd1;
   localparam logic [2:0] FACE_POS_X = 3'd2;
   localparam logic [2:0] FACE_NEG_X = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   localparam logic [2:0] LAST_VERT = 3'd5;

   typedef struct packed {
      logic [3:0] voxel_x;
      logic [7:0] voxel_y;
      logic [3:0] voxel_z;
      logic [7:0] tex_top;
      logic [7:0] tex_base;
      logic [7:0] tex_wall;
      logic [5:0] face_mask;
   } entry_type;

   typedef struct packed {
      logic [4:0] vert_x;
      logic [8:0] vert_y;
      logic [4:0] vert_z;
      logic [3:0] tile_u;
      logic [3:0] tile_v;
      logic       corner_u;
      logic       corner_v;
      logic [2:0] face_index;
      logic       last_vertex;
   } vertex_type;

   typedef struct packed {
      logic dx;
      logic dy;
      logic dz;
      logic cu;
      logic cv;
   } corner_type;

   // corner of a face, picked for vertex k of triangles (c0,c1,c2),(c0,c2,c3)
   function automatic corner_type cvfm_corner(input logic [2:0] face, input logic [2:0] k);
      logic [1:0] c;
      logic [4:0] bits;
      case (k)
         3'd0, 3'd3: c = 2'd0;
         3'd1:       c = 2'd1;
         3'd2, 3'd4: c = 2'd2;
         default:    c = 2'd3;
      endcase
      case ({face, c})
         {FACE_POS_Y, 2'd0}: bits = 5'b01000;
         {FACE_POS_Y, 2'd1}: bits = 5'b01101;
         {FACE_POS_Y, 2'd2}: bits = 5'b11111;
         {FACE_POS_Y, 2'd3}: bits = 5'b11010;
         {FACE_NEG_Y, 2'd0}: bits = 5'b00000;
         {FACE_NEG_Y, 2'd1}: bits = 5'b10010;
         {FACE_NEG_Y, 2'd2}: bits = 5'b10111;
         {FACE_NEG_Y, 2'd3}: bits = 5'b00101;
         {FACE_POS_X, 2'd0}: bits = 5'b10001;
         {FACE_POS_X, 2'd1}: bits = 5'b11000;
         {FACE_POS_X, 2'd2}: bits = 5'b11110;
         {FACE_POS_X, 2'd3}: bits = 5'b10111;
         {FACE_NEG_X, 2'd0}: bits = 5'b00101;
         {FACE_NEG_X, 2'd1}: bits = 5'b01100;
         {FACE_NEG_X, 2'd2}: bits = 5'b01010;
         {FACE_NEG_X, 2'd3}: bits = 5'b00011;
         {FACE_POS_Z, 2'd0}: bits = 5'b00101;
         {FACE_POS_Z, 2'd1}: bits = 5'b10111;
         {FACE_POS_Z, 2'd2}: bits = 5'b11110;
         {FACE_POS_Z, 2'd3}: bits = 5'b01100;
         {FACE_NEG_Z, 2'd0}: bits = 5'b10001;
         {FACE_NEG_Z, 2'd1}: bits = 5'b00011;
         {FACE_NEG_Z, 2'd2}: bits = 5'b01010;
         {FACE_NEG_Z, 2'd3}: bits = 5'b11000;
         default:            bits = 5'b00000;
      endcase
      return corner_type'(bits);
   endfunction

endpackage

`default_nettype wire

// ----- sv/cvfm_chan_if.sv -----
`default_nettype none

interface cvfm_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] voxel_x;
   logic [7:0] voxel_y;
   logic [3:0] voxel_z;
   logic       center_solid;
   logic [7:0] tex_top;
   logic [7:0] tex_base;
   logic [7:0] tex_wall;
   logic [5:0] nb_solid;
   logic [5:0] nb_transparent;

   modport source (
      output valid, voxel_x, voxel_y, voxel_z, center_solid,
             tex_top, tex_base, tex_wall, nb_solid, nb_transparent,
      input  ready
   );
   modport sink (
      input  valid, voxel_x, voxel_y, voxel_z, center_solid,
             tex_top, tex_base, tex_wall, nb_solid, nb_transparent,
      output ready
   );
endinterface

interface cvfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] vert_x;
   logic [8:0] vert_y;
   logic [4:0] vert_z;
   logic [3:0] tile_u;
   logic [3:0] tile_v;
   logic       corner_u;
   logic       corner_v;
   logic [2:0] face_index;
   logic       last_vertex;

   modport source (
      output valid, vert_x, vert_y, vert_z, tile_u, tile_v,
             corner_u, corner_v, face_index, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, vert_x, vert_y, vert_z, tile_u, tile_v,
             corner_u, corner_v, face_index, last_vertex,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/cvfm_front.sv -----
`default_nettype none

module cvfm_front
   import cvfm_pkg::*;
#(
   parameter int unsigned CHUNK_HEIGHT = CHUNK_HEIGHT_DEF
) (
   input  wire logic  reset,
   cvfm_req_if.sink   req_ch,
   input  wire logic  q_full,
   output entry_type  q_wr_data,
   output logic       q_push
);

   localparam logic [Y_CMP_WIDTH-1:0] HEIGHT_LIM = Y_CMP_WIDTH'(CHUNK_HEIGHT);

   logic [Y_CMP_WIDTH-1:0] y_plus;
   logic [Y_CMP_WIDTH-1:0] y_minus;
   logic [5:0]             open_mask;

   always_comb begin
      y_plus  = Y_CMP_WIDTH'(req_ch.voxel_y) + Y_CMP_WIDTH'(1);
      y_minus = Y_CMP_WIDTH'(req_ch.voxel_y) - Y_CMP_WIDTH'(1);
      open_mask = ~(req_ch.nb_solid & ~req_ch.nb_transparent);
      if (y_plus >= HEIGHT_LIM) begin
         open_mask[FACE_POS_Y] = 1'b1;
      end
      if ((req_ch.voxel_y == 8'd0) || (y_minus >= HEIGHT_LIM)) begin
         open_mask[FACE_NEG_Y] = 1'b1;
      end
   end

   assign req_ch.ready = !q_full && !reset;

   // empty and fully hidden voxels are dropped at transfer
   always_comb begin
      q_wr_data.voxel_x    = req_ch.voxel_x;
      q_wr_data.voxel_y    = req_ch.voxel_y;
      q_wr_data.voxel_z    = req_ch.voxel_z;
      q_wr_data.tex_top    = req_ch.tex_top;
      q_wr_data.tex_base   = req_ch.tex_base;
      q_wr_data.tex_wall   = req_ch.tex_wall;
      q_wr_data.face_mask  = open_mask;
      q_push = req_ch.valid && req_ch.ready && req_ch.center_solid && (|open_mask);
   end

endmodule

`default_nettype wire

// ----- sv/cvfm_queue.sv -----
`default_nettype none

module cvfm_queue
   import cvfm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  wr_data,
   output logic            full,
   input  wire logic       pop,
   output logic            not_empty,
   output entry_type       rd_data
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/cvfm_back.sv -----
`default_nettype none

module cvfm_back
   import cvfm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_not_empty,
   input  wire entry_type  q_rd_data,
   output logic            q_pop,
   cvfm_rsp_if.source      rsp_ch
);

   function automatic logic [2:0] first_face(input logic [5:0] mask);
      logic [2:0] f;
      f = FACE_NEG_Z;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            f = 3'(i);
         end
      end
      return f;
   endfunction

   entry_type   cur_ff, cur_in;
   logic        busy_ff, busy_in;
   logic [5:0]  mask_ff, mask_in;
   logic [2:0]  face_ff, face_in;
   logic [2:0]  vert_ff, vert_in;
   logic        out_valid_ff, out_valid_in;
   vertex_type  out_ff, out_in;

   logic        advance;
   logic        face_done;
   logic [5:0]  mask_rest;
   logic        finishing;
   corner_type  crn;
   logic [7:0]  tex;

   always_comb begin
      advance   = !out_valid_ff || rsp_ch.ready;
      face_done = (vert_ff == LAST_VERT);
      mask_rest = mask_ff & ~(6'd1 << face_ff);
      finishing = busy_ff && advance && face_done && (mask_rest == '0);
      q_pop     = q_not_empty && (!busy_ff || finishing);

      crn = cvfm_corner(face_ff, vert_ff);
      case (face_ff)
         FACE_POS_Y: tex = cur_ff.tex_top;
         FACE_NEG_Y: tex = cur_ff.tex_base;
         default:    tex = cur_ff.tex_wall;
      endcase

      out_in.vert_x      = 5'(cur_ff.voxel_x) + 5'(crn.dx);
      out_in.vert_y      = 9'(cur_ff.voxel_y) + 9'(crn.dy);
      out_in.vert_z      = 5'(cur_ff.voxel_z) + 5'(crn.dz);
      out_in.tile_u      = tex[3:0];
      out_in.tile_v      = tex[7:4];
      out_in.corner_u    = crn.cu;
      out_in.corner_v    = crn.cv;
      out_in.face_index  = face_ff;
      out_in.last_vertex = face_done && (mask_rest == '0);

      out_valid_in = advance ? busy_ff : out_valid_ff;

      cur_in  = cur_ff;
      busy_in = busy_ff;
      mask_in = mask_ff;
      face_in = face_ff;
      vert_in = vert_ff;
      if (busy_ff && advance) begin
         if (face_done) begin
            vert_in = '0;
            mask_in = mask_rest;
            face_in = first_face(mask_rest);
            busy_in = (mask_rest != '0);
         end else begin
            vert_in = vert_ff + 3'd1;
         end
      end
      if (q_pop) begin
         cur_in  = q_rd_data;
         busy_in = 1'b1;
         mask_in = q_rd_data.face_mask;
         face_in = first_face(q_rd_data.face_mask);
         vert_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= '0;
         face_ff      <= '0;
         vert_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         mask_ff      <= mask_in;
         face_ff      <= face_in;
         vert_ff      <= vert_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.vert_x      = out_ff.vert_x;
   assign rsp_ch.vert_y      = out_ff.vert_y;
   assign rsp_ch.vert_z      = out_ff.vert_z;
   assign rsp_ch.tile_u      = out_ff.tile_u;
   assign rsp_ch.tile_v      = out_ff.tile_v;
   assign rsp_ch.corner_u    = out_ff.corner_u;
   assign rsp_ch.corner_v    = out_ff.corner_v;
   assign rsp_ch.face_index  = out_ff.face_index;
   assign rsp_ch.last_vertex = out_ff.last_vertex;

endmodule

`default_nettype wire

// ----- sv/culled_voxel_face_mesher_core.sv -----
// Culled voxel face mesher. Each req transfer is one voxel; a solid voxel yields six
// vertices (two triangles) for every face whose neighbor is not solid-and-opaque or
// that lies on the chunk's top or bottom; last_vertex marks the voxel's last vertex.
// The back end emits one vertex per cycle while rsp is ready; the next voxel's first
// vertex follows the previous voxel's last with no gap if it is queued. Empty and
// fully hidden voxels are dropped at transfer. A two-entry queue sits between the
// classifier and vertex generator, so req takes voxels during rsp stalls until full.
`default_nettype none

module culled_voxel_face_mesher_core
   import cvfm_pkg::*;
#(
   parameter int unsigned CHUNK_HEIGHT = CHUNK_HEIGHT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cvfm_req_if.sink   req_ch,
   cvfm_rsp_if.source rsp_ch
);

   entry_type q_wr_data;
   entry_type q_rd_data;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_not_empty;

   cvfm_front #(
      .CHUNK_HEIGHT (CHUNK_HEIGHT)
   ) u_front (
      .reset     (reset),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_wr_data (q_wr_data),
      .q_push    (q_push)
   );

   cvfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   cvfm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rd_data   (q_rd_data),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- test/culled_voxel_face_mesher_core_tb.sv -----
`timescale 1ns / 100ps

module culled_voxel_face_mesher_core_tb;
   import cvfm_pkg::*;

   typedef struct {
      logic [3:0] voxel_x;
      logic [7:0] voxel_y;
      logic [3:0] voxel_z;
      logic       center_solid;
      logic [7:0] tex_top;
      logic [7:0] tex_base;
      logic [7:0] tex_wall;
      logic [5:0] nb_solid;
      logic [5:0] nb_transparent;
   } voxel_rec_type;

   // {dx, dy, dz, cu, cv} per face and corner
   localparam logic [4:0] CORNER_LUT [6][4] = '{
      '{5'b01000, 5'b01101, 5'b11111, 5'b11010},
      '{5'b00000, 5'b10010, 5'b10111, 5'b00101},
      '{5'b10001, 5'b11000, 5'b11110, 5'b10111},
      '{5'b00101, 5'b01100, 5'b01010, 5'b00011},
      '{5'b00101, 5'b10111, 5'b11110, 5'b01100},
      '{5'b10001, 5'b00011, 5'b01010, 5'b11000}
   };
   localparam int TRI_CORNER [6] = '{0, 1, 2, 0, 2, 3};
   localparam int SETTLE_CYCLES = 16;

   logic clock;
   logic reset;

   cvfm_req_if req_ch ();
   cvfm_rsp_if rsp_ch ();

   culled_voxel_face_mesher_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   vertex_type pending_verts[$];
   int         mismatch_count = 0;
   bit         idle_on = 1'b1;
   int         hold_req = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_200_000;
      $display("FAIL culled_voxel_face_mesher_core");
      $finish;
   end

   function automatic voxel_rec_type make_voxel(input logic [3:0] x, input logic [7:0] y,
                                                input logic [3:0] z, input logic solid,
                                                input logic [7:0] tt, input logic [7:0] tb,
                                                input logic [7:0] ts, input logic [5:0] ns,
                                                input logic [5:0] nt);
      voxel_rec_type v;
      v.voxel_x        = x;
      v.voxel_y        = y;
      v.voxel_z        = z;
      v.center_solid   = solid;
      v.tex_top        = tt;
      v.tex_base       = tb;
      v.tex_wall       = ts;
      v.nb_solid       = ns;
      v.nb_transparent = nt;
      return v;
   endfunction

   function automatic void mesh_voxel(input voxel_rec_type v);
      vertex_type verts[$];
      vertex_type vt;
      logic [2:0] face;
      logic [4:0] cb;
      logic [7:0] tex;
      bit         open;
      if (!v.center_solid) return;
      for (int fi = 0; fi < NUM_FACES; fi++) begin
         face = fi[2:0];
         if (face == FACE_POS_Y && int'(v.voxel_y) + 1 >= int'(CHUNK_HEIGHT_DEF))
            open = 1'b1;
         else if (face == FACE_NEG_Y &&
                  (v.voxel_y == 8'd0 || int'(v.voxel_y) - 1 >= int'(CHUNK_HEIGHT_DEF)))
            open = 1'b1;
         else
            open = !(v.nb_solid[fi] && !v.nb_transparent[fi]);
         if (!open) continue;
         case (face)
            FACE_POS_Y: tex = v.tex_top;
            FACE_NEG_Y: tex = v.tex_base;
            default:    tex = v.tex_wall;
         endcase
         for (int k = 0; k < 6; k++) begin
            cb             = CORNER_LUT[fi][TRI_CORNER[k]];
            vt.vert_x      = {1'b0, v.voxel_x} + {4'd0, cb[4]};
            vt.vert_y      = {1'b0, v.voxel_y} + {8'd0, cb[3]};
            vt.vert_z      = {1'b0, v.voxel_z} + {4'd0, cb[2]};
            vt.tile_u      = tex[3:0];
            vt.tile_v      = tex[7:4];
            vt.corner_u    = cb[1];
            vt.corner_v    = cb[0];
            vt.face_index  = face;
            vt.last_vertex = 1'b0;
            verts.push_back(vt);
         end
      end
      if (verts.size() > 0) verts[verts.size() - 1].last_vertex = 1'b1;
      foreach (verts[i]) pending_verts.push_back(verts[i]);
   endfunction

   function automatic void check_field(input string fname, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d, got %0d", fname, want, got);
         mismatch_count++;
      end
   endfunction

   // monitors req transfers, checks rsp transfers and drives rsp ready
   initial begin : rsp_side
      int            stall_left;
      int            hold_left;
      voxel_rec_type seen;
      vertex_type    want;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_ch.valid && req_ch.ready) begin
               seen = make_voxel(req_ch.voxel_x, req_ch.voxel_y, req_ch.voxel_z,
                                 req_ch.center_solid, req_ch.tex_top, req_ch.tex_base,
                                 req_ch.tex_wall, req_ch.nb_solid, req_ch.nb_transparent);
               mesh_voxel(seen);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
               if (pending_verts.size() == 0) begin
                  $error("vertex transfer with no expected vertex pending");
                  mismatch_count++;
               end else begin
                  want = pending_verts.pop_front();
                  check_field("vert_x", want.vert_x, rsp_ch.vert_x);
                  check_field("vert_y", want.vert_y, rsp_ch.vert_y);
                  check_field("vert_z", want.vert_z, rsp_ch.vert_z);
                  check_field("tile_u", want.tile_u, rsp_ch.tile_u);
                  check_field("tile_v", want.tile_v, rsp_ch.tile_v);
                  check_field("corner_u", want.corner_u, rsp_ch.corner_u);
                  check_field("corner_v", want.corner_v, rsp_ch.corner_v);
                  check_field("face_index", want.face_index, rsp_ch.face_index);
                  check_field("last_vertex", want.last_vertex, rsp_ch.last_vertex);
               end
               stall_left = idle_on ? int'($urandom_range(0, 10)) : 0;
            end
         end
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // leaves valid high so back-to-back voxels need no extra edge
   task automatic push_voxel(input voxel_rec_type v);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.voxel_x        <= v.voxel_x;
      req_ch.voxel_y        <= v.voxel_y;
      req_ch.voxel_z        <= v.voxel_z;
      req_ch.center_solid   <= v.center_solid;
      req_ch.tex_top        <= v.tex_top;
      req_ch.tex_base       <= v.tex_base;
      req_ch.tex_wall       <= v.tex_wall;
      req_ch.nb_solid       <= v.nb_solid;
      req_ch.nb_transparent <= v.nb_transparent;
      req_ch.valid          <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_mesh();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_verts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic voxel_rec_type random_voxel();
      voxel_rec_type v;
      logic [31:0]   r;
      r = $urandom;
      v.voxel_x    = r[3:0];
      v.voxel_y    = r[11:4];
      v.voxel_z    = r[15:12];
      v.tex_top    = r[23:16];
      v.tex_base   = r[31:24];
      r = $urandom;
      v.tex_wall       = r[7:0];
      v.nb_solid       = r[13:8];
      v.nb_transparent = r[19:14];
      v.center_solid   = (r[22:20] != 3'd0);
      case (r[27:24])
         4'd0: begin
            v.nb_solid       = 6'h3F;
            v.nb_transparent = 6'h00;
            if (v.voxel_y == 8'd0 || v.voxel_y == 8'hFF) v.voxel_y = 8'd128;
         end
         4'd1: v.nb_solid = 6'h00;
         4'd2: v.voxel_y  = 8'd0;
         4'd3: v.voxel_y  = 8'hFF;
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_face_selection();
      logic [5:0] only_open;
      for (int f = 0; f < NUM_FACES; f++) begin
         only_open = ~(6'd1 << f);
         push_voxel(make_voxel(f[3:0], 8'd100, 4'd15 - f[3:0], 1'b1, 8'hFF, 8'h00,
                               f[0] ? 8'hA5 : 8'h5A, only_open, 6'h00));
      end
      drain_mesh();
   endtask

   task automatic test_empty_and_hidden();
      push_voxel(make_voxel(4'd3, 8'd40, 4'd7, 1'b0, 8'h12, 8'h34, 8'h56, 6'h00, 6'h00));
      push_voxel(make_voxel(4'd0, 8'd0, 4'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 6'h00));
      push_voxel(make_voxel(4'd9, 8'd77, 4'd2, 1'b1, 8'h01, 8'h02, 8'h03, 6'h3F, 6'h00));
      push_voxel(make_voxel(4'd1, 8'd200, 4'd14, 1'b1, 8'h10, 8'hEF, 8'h7F, 6'h3F, 6'h3F));
      push_voxel(make_voxel(4'd6, 8'd5, 4'd6, 1'b1, 8'h80, 8'h08, 8'hC3, 6'h2A, 6'h0A));
      drain_mesh();
   endtask

   task automatic test_chunk_rows();
      push_voxel(make_voxel(4'd4, 8'd0, 4'd4, 1'b1, 8'h11, 8'hF0, 8'h0F, 6'h3F, 6'h00));
      push_voxel(make_voxel(4'd8, 8'hFF, 4'd8, 1'b1, 8'hF0, 8'h11, 8'h0F, 6'h3F, 6'h00));
      push_voxel(make_voxel(4'd15, 8'd0, 4'd15, 1'b1, 8'h00, 8'hFF, 8'h00, 6'h00, 6'h3F));
      push_voxel(make_voxel(4'd15, 8'hFF, 4'd15, 1'b1, 8'hFF, 8'h00, 8'hFF, 6'h00, 6'h00));
      drain_mesh();
   endtask

   // rsp held off long enough that the voxel queue fills and req stalls
   task automatic test_backpressure();
      logic [31:0] r;
      idle_on  = 1'b0;
      hold_req = 200;
      for (int i = 0; i < 8; i++) begin
         r = $urandom;
         push_voxel(make_voxel(r[3:0], r[11:4], r[15:12], 1'b1, r[23:16], r[31:24],
                               r[7:0] ^ r[31:24], 6'h00, r[21:16]));
      end
      drain_mesh();
      idle_on = 1'b1;
   endtask

   task automatic test_random_voxels();
      for (int i = 0; i < 88; i++) begin
         if (i % 22 == 0) begin
            if (i != 0) drain_mesh();
            idle_on = ($urandom_range(0, 3) != 0);
         end
         push_voxel(random_voxel());
      end
      drain_mesh();
      idle_on = 1'b1;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.voxel_x        <= '0;
      req_ch.voxel_y        <= '0;
      req_ch.voxel_z        <= '0;
      req_ch.center_solid   <= 1'b0;
      req_ch.tex_top        <= '0;
      req_ch.tex_base       <= '0;
      req_ch.tex_wall       <= '0;
      req_ch.nb_solid       <= '0;
      req_ch.nb_transparent <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_face_selection();
      test_empty_and_hidden();
      test_chunk_rows();
      test_backpressure();
      test_random_voxels();

      if (mismatch_count == 0)
         $display("PASS culled_voxel_face_mesher_core");
      else
         $display("FAIL culled_voxel_face_mesher_core");
      $finish;
   end

endmodule
